// File: hw/rtl/lz11_token_packer_unit_assert.svh
// ----------------------------------------------------------------------------
// LZ11 token packer assertion macros
// Shared concurrent assertion forms for the packer's internal checks.
// ----------------------------------------------------------------------------
`ifndef LZ11_TOKEN_PACKER_UNIT_ASSERT_SVH
`define LZ11_TOKEN_PACKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZ11TP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz11 token packer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LZ11TP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz11 token packer: next-cycle check failed");

`endif

// File: hw/rtl/lz11tp_pkg.sv
// ----------------------------------------------------------------------------
// LZ11 token packer package
// Constants, token row layout and the control structs shared by the modules.
// ----------------------------------------------------------------------------
package lz11tp_pkg;

  localparam int CHUNKS_PER_GROUP = 8;
  localparam int TOK_IDX_W        = $clog2(CHUNKS_PER_GROUP);
  localparam int BANK_COUNT       = 2;
  localparam int ROW_ADDR_W       = 1 + TOK_IDX_W;
  localparam int ROW_COUNT        = BANK_COUNT * CHUNKS_PER_GROUP;

  localparam logic [7:0]  EMPTY_FLUSH_BYTE = 8'hFF;
  localparam logic [7:0]  FLAG_MSB         = 8'h80;
  localparam logic [3:0]  LONG_MARK        = 4'h1;

  // Thresholds and biases expressed on length_code (match length minus three).
  localparam logic [16:0] SHORT_LC_MAX = 17'd13;      // length 0x10
  localparam logic [16:0] MID_LC_MAX   = 17'h0010D;   // length 0x110
  localparam logic [16:0] LONG_LC_MAX  = 17'h1010D;   // length 0x10110
  localparam logic [16:0] SHORT_LC_ADD = 17'd2;       // length - 1
  localparam logic [16:0] MID_LC_BIAS  = 17'h0000E;   // length - 0x11
  localparam logic [16:0] LONG_LC_BIAS = 17'h0010E;   // length - 0x111

  // One encoded token: up to four bytes, first byte in the low bits.
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  last_idx;
  } row_t;

  // A closed group handed to the output sequencer.
  typedef struct packed {
    logic                 empty;
    logic                 bank;
    logic [7:0]           flag;
    logic [TOK_IDX_W-1:0] last_tok;
  } grp_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  typedef struct packed {
    logic [BANK_COUNT-1:0] bank_busy;
  } grp_stat_t;

endpackage

// File: hw/rtl/lz11_token_packer_unit.sv
// ----------------------------------------------------------------------------
// LZ11 token packer unit
// Packs literal and back-reference tokens into LZ11 groups of flag byte plus
// token bytes and streams the result out one byte per transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                      Per transaction
//  s_*       in   tuser: flush; tdata: distance, length_code   one token or flush
//  m_*       out  tdata: out_byte; tlast: last                 one stream byte
//
// Flow: a token is taken every cycle while its bank is free and is encoded and
// written into its bank from the input register. A group is sent as pick-up, flag
// byte, then its token bytes; the other bank takes the next group meanwhile.
// Reset: synchronous, active high; empties the group and both banks, no clearing pass.
// Stalls: a token stalls while both banks hold closed groups, or when a closing
// item finds the previous group not yet picked up by the output sequencer.
`include "lz11_token_packer_unit_assert.svh"

module lz11_token_packer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [12:0] distance, [29:13] length_code, [31:30] zero
  input  logic        s_tuser,   // [0] flush
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast    // last byte caused by this input transaction
);
  import lz11tp_pkg::*;

  // Input register: holds one transaction until the group builder takes it.
  logic        in_valid;
  logic        in_flush;
  logic [12:0] in_dist;
  logic [16:0] in_lc;
  logic        in_take;

  row_t                  enc_row;
  logic                  enc_match;
  logic [ROW_ADDR_W-1:0] rd_addr;
  row_t                  rd_row;
  logic                  desc_valid;
  logic                  desc_ready;
  grp_desc_t             desc;
  done_t                 done;
  grp_stat_t             stat;

  // The register frees up in the same cycle its content is consumed, so a new
  // transaction can follow every cycle.
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_flush <= s_tuser;
      in_dist  <= s_tdata[12:0];
      in_lc    <= s_tdata[29:13];
    end
  end

  // Token encoding is purely combinational on the registered fields.
  lz11tp_encode u_encode (
    .distance    (in_dist),
    .length_code (in_lc),
    .row         (enc_row),
    .is_match    (enc_match)
  );

  // Group state and the two token banks. A closed group becomes a descriptor
  // and the bank of a non-empty one stays busy until its last byte is emitted.
  lz11tp_group u_group (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_flush   (in_flush),
    .in_row     (enc_row),
    .in_match   (enc_match),
    .in_take    (in_take),
    .rd_addr    (rd_addr),
    .rd_row     (rd_row),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready),
    .done       (done),
    .stat       (stat)
  );

  // Output sequencer with the output register; it walks the bank of the
  // current group token by token and byte by byte.
  lz11tp_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready),
    .rd_addr    (rd_addr),
    .rd_row     (rd_row),
    .done       (done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // A bank can only be released by the sequencer while it is marked busy.
  `LZ11TP_ASSERT_SAME(a_done_bank_busy, done.valid, stat.bank_busy[done.bank])
  // A pending non-empty group must still own its bank.
  `LZ11TP_ASSERT_SAME(a_desc_bank_busy, desc_valid && !desc.empty, stat.bank_busy[desc.bank])
  // A group that has not been picked up stays pending.
  `LZ11TP_ASSERT_NEXT(a_desc_held, desc_valid && !desc_ready, desc_valid)

endmodule

// File: hw/rtl/lz11tp_encode.sv
// ----------------------------------------------------------------------------
// LZ11 token encoder
// Turns one literal or back-reference token into its one to four bytes.
// ----------------------------------------------------------------------------
module lz11tp_encode (
  input  logic [12:0]       distance,
  input  logic [16:0]       length_code,
  output lz11tp_pkg::row_t  row,
  output logic              is_match
);
  import lz11tp_pkg::*;

  logic [12:0] dist_m1;
  logic [3:0]  dhi;
  logic [7:0]  dlo;
  logic [16:0] lc_p2;
  logic [16:0] mid_diff;
  logic [16:0] lc_sat;
  logic [16:0] long_diff;
  logic [7:0]  mid_len;
  logic [15:0] long_len;

  assign dist_m1   = distance - 13'd1;
  assign dhi       = dist_m1[11:8];
  assign dlo       = dist_m1[7:0];
  assign lc_p2     = length_code + SHORT_LC_ADD;
  assign mid_diff  = length_code - MID_LC_BIAS;
  assign mid_len   = mid_diff[7:0];
  assign lc_sat    = (length_code > LONG_LC_MAX) ? LONG_LC_MAX : length_code;
  assign long_diff = lc_sat - LONG_LC_BIAS;
  assign long_len  = long_diff[15:0];
  assign is_match  = (distance != 13'd0);

  always_comb begin
    priority if (!is_match) begin
      row.bytes    = {24'd0, length_code[7:0]};
      row.last_idx = 2'd0;
    end else if (length_code <= SHORT_LC_MAX) begin
      row.bytes    = {16'd0, dlo, lc_p2[3:0], dhi};
      row.last_idx = 2'd1;
    end else if (length_code <= MID_LC_MAX) begin
      row.bytes    = {8'd0, dlo, mid_len[3:0], dhi, 4'd0, mid_len[7:4]};
      row.last_idx = 2'd2;
    end else begin
      row.bytes    = {dlo, long_len[3:0], dhi, long_len[11:4], LONG_MARK, long_len[15:12]};
      row.last_idx = 2'd3;
    end
  end

endmodule

// File: hw/rtl/lz11tp_group.sv
// ----------------------------------------------------------------------------
// LZ11 group builder
// Collects encoded tokens into one of two banks and closes groups.
// ----------------------------------------------------------------------------
module lz11tp_group (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_flush,
  input  lz11tp_pkg::row_t                  in_row,
  input  logic                              in_match,
  output logic                              in_take,
  input  logic [lz11tp_pkg::ROW_ADDR_W-1:0] rd_addr,
  output lz11tp_pkg::row_t                  rd_row,
  output logic                              desc_valid,
  output lz11tp_pkg::grp_desc_t             desc,
  input  logic                              desc_ready,
  input  lz11tp_pkg::done_t                 done,
  output lz11tp_pkg::grp_stat_t             stat
);
  import lz11tp_pkg::*;

  row_t                  rows [ROW_COUNT];
  logic [TOK_IDX_W-1:0]  chunk_count;
  logic [7:0]            flag_bits;
  logic [7:0]            flag_next;
  logic                  wbank;
  logic [BANK_COUNT-1:0] bank_busy;
  logic [BANK_COUNT-1:0] bank_busy_next;
  logic                  tok_close;
  logic                  need_desc;
  logic                  tok_take;
  logic                  close;
  logic                  empty_flush;

  assign tok_close   = (chunk_count == TOK_IDX_W'(CHUNKS_PER_GROUP - 1));
  assign need_desc   = in_flush || tok_close;
  assign empty_flush = in_flush && (chunk_count == '0);
  assign in_take     = in_valid && !(need_desc && desc_valid)
                       && (in_flush || !bank_busy[wbank]);
  assign tok_take    = in_take && !in_flush;
  assign close       = in_take && need_desc;
  assign flag_next   = flag_bits | (in_match ? (FLAG_MSB >> chunk_count) : 8'h00);

  assign rd_row         = rows[rd_addr];
  assign stat.bank_busy = bank_busy;

  // A bank is released by the sequencer and claimed by a closing group; the
  // two never name the same bank in one cycle.
  always_comb begin
    bank_busy_next = bank_busy;
    if (done.valid) begin
      bank_busy_next[done.bank] = 1'b0;
    end
    if (close && !empty_flush) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
      flag_bits   <= '0;
      wbank       <= 1'b0;
      bank_busy   <= '0;
      desc_valid  <= 1'b0;
    end else begin
      bank_busy <= bank_busy_next;
      if (close) begin
        desc_valid  <= 1'b1;
        chunk_count <= '0;
        flag_bits   <= '0;
        if (!empty_flush) begin
          wbank <= ~wbank;
        end
      end else begin
        if (desc_valid && desc_ready) begin
          desc_valid <= 1'b0;
        end
        if (tok_take) begin
          chunk_count <= chunk_count + 1'b1;
          flag_bits   <= flag_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      desc.empty    <= empty_flush;
      desc.bank     <= wbank;
      desc.flag     <= in_flush ? flag_bits : flag_next;
      desc.last_tok <= in_flush ? (chunk_count - 1'b1) : chunk_count;
    end
    if (tok_take) begin
      rows[{wbank, chunk_count}] <= in_row;
    end
  end

endmodule

// File: hw/rtl/lz11tp_drain.sv
// ----------------------------------------------------------------------------
// LZ11 output sequencer
// Sends each group's flag and token bytes, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module lz11tp_drain (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              desc_valid,
  input  lz11tp_pkg::grp_desc_t             desc,
  output logic                              desc_ready,
  output logic [lz11tp_pkg::ROW_ADDR_W-1:0] rd_addr,
  input  lz11tp_pkg::row_t                  rd_row,
  output lz11tp_pkg::done_t                 done,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast
);
  import lz11tp_pkg::*;

  grp_desc_t            cur;
  logic                 active;
  logic                 phase_flag;
  logic [TOK_IDX_W-1:0] tok_idx;
  logic [1:0]           byte_idx;
  logic                 load;
  logic                 emit;
  logic                 tok_last;
  logic                 byte_last;
  logic                 group_end;
  logic [7:0]           out_byte;
  logic                 out_last;

  assign desc_ready = !active;
  assign load       = !m_tvalid || m_tready;
  assign emit       = active && load;
  assign rd_addr    = {cur.bank, tok_idx};
  assign tok_last   = (tok_idx == cur.last_tok);
  assign byte_last  = (byte_idx == rd_row.last_idx);
  assign group_end  = cur.empty || (!phase_flag && tok_last && byte_last);
  assign done.valid = emit && !cur.empty && !phase_flag && tok_last && byte_last;
  assign done.bank  = cur.bank;

  always_comb begin
    priority if (cur.empty) begin
      out_byte = EMPTY_FLUSH_BYTE;
      out_last = 1'b1;
    end else if (phase_flag) begin
      out_byte = cur.flag;
      out_last = 1'b0;
    end else begin
      out_byte = rd_row.bytes[{byte_idx, 3'b000} +: 8];
      out_last = tok_last && byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      phase_flag <= 1'b0;
      tok_idx    <= '0;
      byte_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= active;
      end
      if (desc_valid && desc_ready) begin
        active     <= 1'b1;
        phase_flag <= 1'b1;
        tok_idx    <= '0;
        byte_idx   <= '0;
      end else if (emit) begin
        if (group_end) begin
          active <= 1'b0;
        end else if (phase_flag) begin
          phase_flag <= 1'b0;
        end else if (byte_last) begin
          byte_idx <= '0;
          tok_idx  <= tok_idx + 1'b1;
        end else begin
          byte_idx <= byte_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      cur <= desc;
    end
    if (emit) begin
      m_tdata <= out_byte;
      m_tlast <= out_last;
    end
  end

endmodule
